// ===== src/pse_pkg.sv =====
// Shared types, constants and operation codes for the positional stack engine.
package pse_pkg;

    localparam int DEPTH   = 128;
    localparam int WORD_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int POS_W   = 8;
    localparam int STAT_W  = 2;
    localparam int CNT_OUT_W = 8;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W   = ((COUNT_W > POS_W) ? COUNT_W : POS_W) + 1;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH       = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP        = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PEEK       = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INS_BOTTOM = 3'd3;
    localparam logic [FUNC_W-1:0] FN_INS_AT     = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DEL_BOTTOM = 3'd5;
    localparam logic [FUNC_W-1:0] FN_DEL_AT     = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_INSERT,
        SH_DELETE
    } shift_kind_t;

    // Broadcast to every cell: what to do and where (0 is the top cell)
    typedef struct packed {
        shift_kind_t               kind;
        logic [IDX_W-1:0]          idx;
        logic signed [WORD_W-1:0]  value;
    } shift_cmd_t;

    // Result of one request as it will be reported
    typedef struct packed {
        logic signed [WORD_W-1:0]  top_value;
        logic [STAT_W-1:0]         status;
        logic [COUNT_W-1:0]        count;
    } result_t;

endpackage

// ===== src/positional_stack_engine.sv =====
// Top level of the positional stack engine: cell chain, decoder and result register.
//
// Bounded stack of 128 signed 32-bit words held in a chain of cells, the top
// in cell 0. Every request (push, pop, peek, insert or delete at the bottom or
// at position k from the top) is done by all cells together: the decoder broadcasts
// the gap position and each cell holds, loads or takes its neighbour's word
// in the same edge. A new request is taken every cycle; its result appears
// in the output register on the following cycle and the input stays ready as
// long as that register is empty or being emptied. No clearing pass follows
// reset; only entries below the fill count are ever reported.
module positional_stack_engine
    import pse_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [FUNC_W-1:0]            func,
    input  logic signed [WORD_W-1:0]     value,
    input  logic [POS_W-1:0]             position,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [WORD_W-1:0]     top_value,
    output logic [STAT_W-1:0]            status,
    output logic [CNT_OUT_W-1:0]         entry_count
);

    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    result_t                   res_reg;
    result_t                   res;
    shift_cmd_t                cmd;
    logic                      accept;
    logic signed [WORD_W-1:0]  cell_data [DEPTH];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Decode the request
    pse_ctrl u_ctrl (
        .func     (func),
        .value    (value),
        .position (position),
        .count    (count_reg),
        .top0     (cell_data[0]),
        .top1     (cell_data[1]),
        .cmd      (cmd),
        .res      (res)
    );

    // Build the cell chain; the ends see zero beyond them
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] above_w;
        logic signed [WORD_W-1:0] below_w;
        if (i == 0)
        begin : g_top
            assign above_w = '0;
        end
        else
        begin : g_mid_a
            assign above_w = cell_data[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_bot
            assign below_w = '0;
        end
        else
        begin : g_mid_b
            assign below_w = cell_data[i+1];
        end
        pse_cell u_cell (
            .clk   (clk),
            .en    (accept),
            .cmd   (cmd),
            .index (IDX_W'(i)),
            .above (above_w),
            .below (below_w),
            .data  (cell_data[i])
        );
    end

    // Advance the fill count and the result valid flag
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            count_next     = res.count;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign top_value   = res_reg.top_value;
    assign status      = res_reg.status;
    assign entry_count = CNT_OUT_W'(res_reg.count);

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_count_report : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid && entry_count == CNT_OUT_W'(count_reg))
        else $error("reported count differs from stored count");

    a_full_report : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> entry_count == CNT_OUT_W'(DEPTH))
        else $error("full status with stack not full");

    a_empty_report : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> entry_count == '0 && top_value == -1)
        else $error("empty status with entries held");

endmodule

// ===== src/pse_cell.sv =====
// One storage cell of the stack chain; entry index 0 is the top of the stack.
module pse_cell
    import pse_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  shift_cmd_t                cmd,
    input  logic [IDX_W-1:0]          index,
    input  logic signed [WORD_W-1:0]  above,
    input  logic signed [WORD_W-1:0]  below,
    output logic signed [WORD_W-1:0]  data
);

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;

    // Hold above the gap, load at the gap, shift towards the bottom or the top
    always_comb
    begin
        data_next = data_reg;
        case (cmd.kind)
            SH_INSERT:
            begin
                if (index == cmd.idx)
                begin
                    data_next = cmd.value;
                end
                else if (index > cmd.idx)
                begin
                    data_next = above;
                end
            end
            SH_DELETE:
            begin
                if (index >= cmd.idx)
                begin
                    data_next = below;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

// ===== src/pse_ctrl.sv =====
// Request decoder: checks the request, builds the cell command and the result.
module pse_ctrl
    import pse_pkg::*;
(
    input  logic [FUNC_W-1:0]         func,
    input  logic signed [WORD_W-1:0]  value,
    input  logic [POS_W-1:0]          position,
    input  logic [COUNT_W-1:0]        count,
    input  logic signed [WORD_W-1:0]  top0,
    input  logic signed [WORD_W-1:0]  top1,
    output shift_cmd_t                cmd,
    output result_t                   res
);

    logic [CMP_W-1:0]   c_w;
    logic [CMP_W-1:0]   k_w;
    logic               full;
    logic               empty;
    logic [COUNT_W-1:0] count_next;
    logic [STAT_W-1:0]  status;

    assign c_w   = CMP_W'(count);
    assign k_w   = CMP_W'(position);
    assign full  = (c_w >= CMP_W'(DEPTH));
    assign empty = (count == '0);

    // Decode the request against the current fill
    always_comb
    begin
        cmd.kind   = SH_NONE;
        cmd.idx    = '0;
        cmd.value  = value;
        status     = ST_OK;
        count_next = count;
        case (func)
            FN_PUSH:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd.kind   = SH_INSERT;
                    count_next = count + COUNT_W'(1);
                end
            end
            FN_POP:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    cmd.kind   = SH_DELETE;
                    count_next = count - COUNT_W'(1);
                end
            end
            FN_PEEK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
            end
            FN_INS_BOTTOM:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd.kind   = SH_INSERT;
                    cmd.idx    = IDX_W'(count);
                    count_next = count + COUNT_W'(1);
                end
            end
            FN_INS_AT:
            begin
                if (k_w == '0 || k_w > c_w + CMP_W'(1))
                begin
                    status = ST_BADPOS;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd.kind   = SH_INSERT;
                    cmd.idx    = IDX_W'(k_w - CMP_W'(1));
                    count_next = count + COUNT_W'(1);
                end
            end
            FN_DEL_BOTTOM:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    cmd.kind   = SH_DELETE;
                    cmd.idx    = IDX_W'(count - COUNT_W'(1));
                    count_next = count - COUNT_W'(1);
                end
            end
            FN_DEL_AT:
            begin
                if (k_w == '0 || k_w > c_w)
                begin
                    status = ST_BADPOS;
                end
                else
                begin
                    cmd.kind   = SH_DELETE;
                    cmd.idx    = IDX_W'(k_w - CMP_W'(1));
                    count_next = count - COUNT_W'(1);
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // Predict the top entry after the shift and report the status and new fill count
    always_comb
    begin
        res.status = status;
        res.count  = count_next;
        if (count_next == '0)
        begin
            res.top_value = '1;
        end
        else if (cmd.kind == SH_INSERT && cmd.idx == '0)
        begin
            res.top_value = value;
        end
        else if (cmd.kind == SH_DELETE && cmd.idx == '0)
        begin
            res.top_value = top1;
        end
        else
        begin
            res.top_value = top0;
        end
    end

endmodule

// ===== tb/positional_stack_engine_tb.sv =====
// Self-checking testbench for the positional stack engine: directed, full-stack and random requests.
`timescale 1ns / 100ps

module positional_stack_engine_tb;
    import pse_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_NEG = -32'sd1;

    typedef struct {
        logic signed [WORD_W-1:0] top_value;
        logic [STAT_W-1:0]        status;
        logic [CNT_OUT_W-1:0]     entry_count;
    } stack_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [WORD_W-1:0] top_value;
    logic [STAT_W-1:0]        status;
    logic [CNT_OUT_W-1:0]     entry_count;

    // Predicted stack contents, bottom at index 0
    logic signed [WORD_W-1:0] model_words [DEPTH];
    int                       model_fill;

    stack_result_t            pending_results [$];
    stack_result_t            oldest_result;
    int                       error_count;
    int                       send_idle_pct;
    int                       recv_idle_pct;
    int                       quiet_cycles;

    positional_stack_engine uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .top_value   (top_value),
        .status      (status),
        .entry_count (entry_count)
    );

    // Generate the 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Open a gap at index idx and write w there
    function automatic void open_gap(int idx, logic signed [WORD_W-1:0] w);
        int i;
        for (i = model_fill; i > idx; i--)
            model_words[i] = model_words[i-1];
        model_words[idx] = w;
        model_fill++;
    endfunction

    // Remove the entry at index idx and close the gap
    function automatic void close_gap(int idx);
        int i;
        for (i = idx; i + 1 < model_fill; i++)
            model_words[i] = model_words[i+1];
        model_fill--;
    endfunction

    // Apply one request to the predicted stack and return its result
    function automatic stack_result_t predict_stack_op(logic [FUNC_W-1:0] fn,
                                                       logic signed [WORD_W-1:0] w,
                                                       logic [POS_W-1:0] k);
        stack_result_t r;
        int            kk;
        kk = int'(k);
        r.status = ST_OK;
        case (fn)
            FN_PUSH:
                if (model_fill >= DEPTH) r.status = ST_FULL;
                else open_gap(model_fill, w);
            FN_POP:
                if (model_fill == 0) r.status = ST_EMPTY;
                else model_fill--;
            FN_PEEK:
                if (model_fill == 0) r.status = ST_EMPTY;
            FN_INS_BOTTOM:
                if (model_fill >= DEPTH) r.status = ST_FULL;
                else open_gap(0, w);
            FN_INS_AT:
                // position is checked before fullness
                if (kk < 1 || kk > model_fill + 1) r.status = ST_BADPOS;
                else if (model_fill >= DEPTH) r.status = ST_FULL;
                else open_gap(model_fill + 1 - kk, w);
            FN_DEL_BOTTOM:
                if (model_fill == 0) r.status = ST_EMPTY;
                else close_gap(0);
            FN_DEL_AT:
                if (kk < 1 || kk > model_fill) r.status = ST_BADPOS;
                else close_gap(model_fill - kk);
            default: ;
        endcase
        r.top_value   = (model_fill == 0) ? WORD_NEG : model_words[model_fill-1];
        r.entry_count = CNT_OUT_W'(model_fill);
        return r;
    endfunction

    // Present one request, hold it until taken, then record its expected result
    task automatic send_request(input logic [FUNC_W-1:0] fn,
                                input logic signed [WORD_W-1:0] w,
                                input logic [POS_W-1:0] k);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= fn;
        value    <= w;
        position <= k;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(predict_stack_op(fn, w, k));
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return WORD_NEG;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Requests on an empty stack: every one is rejected or harmless
    task automatic test_empty_stack();
        send_request(FN_POP,        '0,       8'd0);
        send_request(FN_PEEK,       '0,       8'd0);
        send_request(FN_DEL_BOTTOM, '0,       8'd0);
        send_request(FN_DEL_AT,     '0,       8'd1);
        send_request(FN_DEL_AT,     '0,       8'd0);
        send_request(FN_INS_AT,     WORD_MAX, 8'd0);
        send_request(FN_INS_AT,     WORD_MAX, 8'd2);
        send_request(FN_UNUSED,     WORD_NEG, 8'hff);
    endtask

    // Extreme words and each positional operation on a short stack
    task automatic test_positional_ops();
        send_request(FN_PUSH,       WORD_MAX, 8'd0);
        send_request(FN_PUSH,       WORD_MIN, 8'hff);
        send_request(FN_PUSH,       WORD_NEG, 8'd0);
        send_request(FN_PEEK,       '0,       8'd0);
        send_request(FN_INS_BOTTOM, '0,       8'd0);
        send_request(FN_INS_AT,     32'sd11,  8'd1);
        send_request(FN_INS_AT,     32'sd22,  8'd6);
        send_request(FN_INS_AT,     32'sd33,  8'd3);
        send_request(FN_INS_AT,     32'sd44,  8'hff);
        send_request(FN_DEL_AT,     '0,       8'd2);
        send_request(FN_DEL_AT,     '0,       8'd6);
        send_request(FN_DEL_AT,     '0,       8'hff);
        send_request(FN_DEL_BOTTOM, '0,       8'd0);
        send_request(FN_UNUSED,     WORD_MAX, 8'd3);
        send_request(FN_POP,        '0,       8'd0);
    endtask

    // Fill to depth, then hit every rejection a full stack can give
    task automatic test_full_stack();
        int k;
        while (model_fill < DEPTH)
        begin
            k = $urandom_range(model_fill + 1, 1);
            case ($urandom_range(2))
                0:       send_request(FN_PUSH,       pick_word(), POS_W'($urandom));
                1:       send_request(FN_INS_BOTTOM, pick_word(), POS_W'($urandom));
                default: send_request(FN_INS_AT,     pick_word(), POS_W'(k));
            endcase
        end
        send_request(FN_PUSH,       32'sd5, 8'd0);
        send_request(FN_INS_BOTTOM, 32'sd5, 8'd0);
        send_request(FN_INS_AT,     32'sd5, POS_W'(DEPTH + 1));
        send_request(FN_INS_AT,     32'sd5, POS_W'(DEPTH + 2));
        send_request(FN_INS_AT,     32'sd5, 8'd0);
        send_request(FN_DEL_AT,     '0,     POS_W'(DEPTH + 1));
        send_request(FN_DEL_AT,     '0,     POS_W'(DEPTH));
        send_request(FN_INS_AT,     WORD_MIN, POS_W'(DEPTH));
        send_request(FN_PEEK,       '0,     8'd0);
        send_request(FN_POP,        '0,     8'd0);
    endtask

    // Random requests, mostly well formed, with the growth bias changing in stretches
    task automatic test_random_ops(input int n);
        int                       i;
        int                       grow_pct;
        int                       roll;
        logic [FUNC_W-1:0]        fn;
        logic signed [WORD_W-1:0] w;
        logic [POS_W-1:0]         k;
        grow_pct = 50;
        for (i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       grow_pct = 20;
                    1:       grow_pct = 50;
                    default: grow_pct = 80;
                endcase
            end
            roll = $urandom_range(99);
            if (roll < grow_pct)
            begin
                case ($urandom_range(2))
                    0:       fn = FN_PUSH;
                    1:       fn = FN_INS_BOTTOM;
                    default: fn = FN_INS_AT;
                endcase
            end
            else if (roll < 94)
            begin
                case ($urandom_range(3))
                    0:       fn = FN_POP;
                    1:       fn = FN_PEEK;
                    2:       fn = FN_DEL_BOTTOM;
                    default: fn = FN_DEL_AT;
                endcase
            end
            else
                fn = FUNC_W'($urandom_range(7));
            w = pick_word();
            // aim positions at the valid range most of the time
            if ($urandom_range(9) == 0)
                k = POS_W'($urandom_range(255));
            else if (fn == FN_INS_AT)
                k = POS_W'($urandom_range(model_fill + 1, 1));
            else if (fn == FN_DEL_AT && model_fill > 0)
                k = POS_W'($urandom_range(model_fill, 1));
            else
                k = POS_W'($urandom_range(255));
            send_request(fn, w, k);
            if (i == n / 2)
                pause_until_drained();
        end
    endtask

    // Compare each result with the oldest prediction, then drive the receiver
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: top_value %0d status %0d entry_count %0d",
                       top_value, status, entry_count);
                error_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (top_value !== oldest_result.top_value)
                begin
                    $error("top_value: expected %0d, actual %0d",
                           oldest_result.top_value, top_value);
                    error_count++;
                end
                if (status !== oldest_result.status)
                begin
                    $error("status: expected %0d, actual %0d", oldest_result.status, status);
                    error_count++;
                end
                if (entry_count !== oldest_result.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d",
                           oldest_result.entry_count, entry_count);
                    error_count++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // End the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Reset, run the tests in turn, drain and report
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_ready     = 1'b0;
        func          = '0;
        value         = '0;
        position      = '0;
        model_fill    = 0;
        error_count   = 0;
        quiet_cycles  = 0;
        send_idle_pct = 31;
        recv_idle_pct = 67;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_stack();
        test_positional_ops();
        test_full_stack();
        test_random_ops(114);
        pause_until_drained();

        send_idle_pct = 67;
        recv_idle_pct = 31;
        test_random_ops(114);
        pause_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_ops(114);

        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
